[design/dp2_pkg.sv]
`default_nettype none
package dp2_pkg;

    // Widths fixed by the interface
    localparam int EXP_W    = 10;
    localparam int DIGIT_W  = 4;
    localparam int COUNT_W  = 6;

    // Default digit store depth
    localparam int DIGITS_DEF = 32;

    // Digit threshold at which doubling carries out
    localparam logic [DIGIT_W-1:0] CARRY_LIMIT = 4'd5;
    localparam logic [DIGIT_W:0]   RADIX       = 5'd10;

    // Controller states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DOUBLE = 3'b010,
        ST_SEND   = 3'b100
    } t_dp2_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic dbl;
        logic send;
    } t_dp2_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic exp_zero;
        logic last_pass;
        logic last_digit;
    } t_dp2_status;

    // One BCD doubling of a digit with carry in
    function automatic logic [DIGIT_W-1:0] dbl_digit(input logic [DIGIT_W-1:0] d,
                                                     input logic                cin);
        logic [DIGIT_W:0] v;
        v = {d, cin};
        if (v >= RADIX) begin
            v = v - RADIX;
        end
        return v[DIGIT_W-1:0];
    endfunction

endpackage
`default_nettype wire

[design/dp2_ctrl.sv]
`default_nettype none
module dp2_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    input  wire dp2_pkg::t_dp2_status i_status,
    output dp2_pkg::t_dp2_cmd         o_cmd,
    output logic                      busy
);
    import dp2_pkg::*;

    t_dp2_state r_state;
    t_dp2_state n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.exp_zero ? ST_SEND : ST_DOUBLE;
                end
            end
            ST_DOUBLE: begin
                o_cmd.dbl = 1'b1;
                if (i_status.last_pass) begin
                    n_state = ST_SEND;
                end
            end
            ST_SEND: begin
                o_cmd.send = 1'b1;
                if (i_status.last_digit) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != ST_IDLE);

endmodule
`default_nettype wire

[design/dp2_datapath.sv]
`default_nettype none
module dp2_datapath #(
    parameter int DIGITS = dp2_pkg::DIGITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire dp2_pkg::t_dp2_cmd             i_cmd,
    input  wire logic [dp2_pkg::EXP_W-1:0]     i_exponent,
    output dp2_pkg::t_dp2_status               o_status,
    output logic                               o_digit_valid,
    output logic [dp2_pkg::DIGIT_W-1:0]        o_digit_value,
    output logic [dp2_pkg::COUNT_W-1:0]        o_digit_count,
    output logic                               o_overflowed,
    output logic                               o_last_digit
);
    import dp2_pkg::*;

    localparam int CW = $clog2(DIGITS + 1);
    localparam int IW = $clog2(DIGITS);

    logic [DIGIT_W-1:0] r_digit [DIGITS];
    logic [DIGIT_W-1:0] n_digit [DIGITS];
    logic [DIGITS-1:0]  carry;
    logic [CW-1:0]      r_used;
    logic [CW-1:0]      n_used;
    logic [CW-1:0]      used_m1;
    logic [IW-1:0]      r_idx;
    logic [CW-1:0]      idx_p1;
    logic [EXP_W-1:0]   r_pass;
    logic               r_ovf;
    logic [CW+COUNT_W-1:0] count_ext;

    // Carry out of each cell depends only on its own digit
    always_comb begin
        for (int j = 0; j < DIGITS; j++) begin
            carry[j] = (r_digit[j] >= CARRY_LIMIT);
        end
    end

    assign used_m1 = r_used - CW'(1);

    // Next digit store: load, double, or shift down during send
    always_comb begin
        for (int j = 0; j < DIGITS; j++) begin
            n_digit[j] = r_digit[j];
        end
        if (i_cmd.load) begin
            for (int j = 0; j < DIGITS; j++) begin
                n_digit[j] = (j == 0) ? DIGIT_W'(1) : '0;
            end
        end else if (i_cmd.dbl) begin
            for (int j = 0; j < DIGITS; j++) begin
                n_digit[j] = dbl_digit(r_digit[j], (j == 0) ? 1'b0 : carry[(j == 0) ? 0 : j-1]);
            end
        end else if (i_cmd.send) begin
            for (int j = 0; j < DIGITS; j++) begin
                n_digit[j] = (j == DIGITS-1) ? '0 : r_digit[(j == DIGITS-1) ? j : j+1];
            end
        end
    end

    // Open a new digit when the top used digit carries out
    always_comb begin
        n_used = r_used;
        if (i_cmd.load) begin
            n_used = CW'(1);
        end else if (i_cmd.dbl && carry[used_m1[IW-1:0]] && (r_used != CW'(DIGITS))) begin
            n_used = r_used + CW'(1);
        end
    end

    // Advance digit store, counters and overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < DIGITS; j++) begin
                r_digit[j] <= (j == 0) ? DIGIT_W'(1) : '0;
            end
            r_used <= CW'(1);
            r_ovf  <= 1'b0;
            r_idx  <= '0;
            r_pass <= '0;
        end else begin
            for (int j = 0; j < DIGITS; j++) begin
                r_digit[j] <= n_digit[j];
            end
            r_used <= n_used;
            if (i_cmd.load) begin
                r_ovf  <= 1'b0;
                r_idx  <= '0;
                r_pass <= i_exponent;
            end else if (i_cmd.dbl) begin
                r_pass <= r_pass - EXP_W'(1);
                if (carry[DIGITS-1]) begin
                    r_ovf <= 1'b1;
                end
            end else if (i_cmd.send) begin
                r_idx <= r_idx + IW'(1);
            end
        end
    end

    assign idx_p1 = CW'(r_idx) + CW'(1);

    // Status back to the controller
    assign o_status.exp_zero   = (i_exponent == '0);
    assign o_status.last_pass  = (r_pass == EXP_W'(1));
    assign o_status.last_digit = (idx_p1 == r_used);

    // Result word, least significant digit sits in cell zero
    assign count_ext     = {{COUNT_W{1'b0}}, r_used};
    assign o_digit_valid = i_cmd.send;
    assign o_digit_value = r_digit[0];
    assign o_digit_count = count_ext[COUNT_W-1:0];
    assign o_overflowed  = r_ovf;
    assign o_last_digit  = i_cmd.send && (idx_p1 == r_used);

endmodule
`default_nettype wire

[design/decimal_power_of_two_top.sv]
`default_nettype none
// Decimal power of two: computes 2^n as decimal digits by repeated doubling.
// Input: pulse start with i_exponent while busy is low; the word is taken on
// that edge and busy rises on the next cycle.
// The digit store is set to the single digit 1, then doubled once per cycle,
// all DIGITS cells in parallel, n times in all.
// Output: one word per digit, least significant first, each shown for one
// cycle with o_digit_valid high; o_last_digit marks the most significant
// digit. o_digit_count and o_overflowed hold steady while digits are shown.
// If a carry leaves the top cell it is dropped and o_overflowed is set, so
// the digits shown are 2^n modulo 10^DIGITS.
// An item runs through a load, the n doubling passes and one send per digit;
// one item is in work at a time.
// The receiver cannot stall: each digit is accepted on the edge ending its
// cycle. Synchronous active-low reset returns the controller to idle with
// busy low.
module decimal_power_of_two_top #(
    parameter int DIGITS = dp2_pkg::DIGITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [dp2_pkg::EXP_W-1:0]  i_exponent,
    output logic                            o_digit_valid,
    output logic [dp2_pkg::DIGIT_W-1:0]     o_digit_value,
    output logic [dp2_pkg::COUNT_W-1:0]     o_digit_count,
    output logic                            o_overflowed,
    output logic                            o_last_digit
);
    import dp2_pkg::*;

    t_dp2_cmd    cmd;
    t_dp2_status status;

    // Controller
    dp2_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    // Digit cells and counters
    dp2_datapath #(
        .DIGITS (DIGITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_exponent    (i_exponent),
        .o_status      (status),
        .o_digit_valid (o_digit_valid),
        .o_digit_value (o_digit_value),
        .o_digit_count (o_digit_count),
        .o_overflowed  (o_overflowed),
        .o_last_digit  (o_last_digit)
    );

    // Digits only go out while an item is in work
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_digit_valid |-> busy)
        else $error("digit word outside busy");

    // Every digit shown is a decimal digit
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_digit_valid |-> (o_digit_value <= DIGIT_W'(9)))
        else $error("digit out of decimal range");

    // A taken item makes the block busy next cycle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("start not taken");

    // The run ends after the last digit
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_digit_valid && o_last_digit) |=> (!o_digit_valid && !busy))
        else $error("digit word after last digit");

endmodule
`default_nettype wire
